>>> rtl/vna_pkg.sv
package vna_pkg;

    localparam int VERTEX_DEPTH = 1024;
    localparam int COORD_WIDTH  = 16;
    localparam int SUM_WIDTH    = 48;
    localparam int IDX_WIDTH    = $clog2(VERTEX_DEPTH);
    localparam int IN_IDX_WIDTH = 10;
    localparam int IN_COORD_WIDTH = 16;
    localparam int OUT_WIDTH    = 48;
    localparam int EDGE_WIDTH   = COORD_WIDTH + 1;
    localparam int PROD_WIDTH   = 2 * EDGE_WIDTH;
    localparam int CROSS_WIDTH  = PROD_WIDTH + 1;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_FACE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic KIND_FACE = 1'b0;
    localparam logic KIND_VERT = 1'b1;

    typedef struct packed {
        logic [1:0]                 op;
        logic [IN_IDX_WIDTH-1:0]    vert_index;
        logic signed [IN_COORD_WIDTH-1:0] coord_x;
        logic signed [IN_COORD_WIDTH-1:0] coord_y;
        logic signed [IN_COORD_WIDTH-1:0] coord_z;
        logic [IN_IDX_WIDTH-1:0]    corner_a;
        logic [IN_IDX_WIDTH-1:0]    corner_b;
        logic [IN_IDX_WIDTH-1:0]    corner_c;
    } in_word_t;

    typedef struct packed {
        logic                       kind;
        logic signed [OUT_WIDTH-1:0] norm_x;
        logic signed [OUT_WIDTH-1:0] norm_y;
        logic signed [OUT_WIDTH-1:0] norm_z;
    } out_word_t;

    // Classified command passed from the front end to the execution unit.
    typedef struct packed {
        logic [1:0]                 op;
        logic [2:0]                 in_range;
        logic [IDX_WIDTH-1:0]       idx_a;
        logic [IDX_WIDTH-1:0]       idx_b;
        logic [IDX_WIDTH-1:0]       idx_c;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
    } cmd_t;

    function automatic logic [IDX_WIDTH-1:0] idx_cut(input logic [IN_IDX_WIDTH-1:0] v);
        logic [31:0] w;
        begin
            w = 32'(v);
            idx_cut = w[IDX_WIDTH-1:0];
        end
    endfunction

    function automatic logic in_depth(input logic [IN_IDX_WIDTH-1:0] v);
        begin
            in_depth = (33'(v) < 33'(VERTEX_DEPTH));
        end
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] coord_cut(
        input logic signed [IN_COORD_WIDTH-1:0] v);
        logic signed [31:0] w;
        begin
            w = 32'(v);
            coord_cut = w[COORD_WIDTH-1:0];
        end
    endfunction

    // Saturating add of two SUM_WIDTH values.
    function automatic logic signed [SUM_WIDTH-1:0] sat_add(
        input logic signed [SUM_WIDTH-1:0] a, input logic signed [SUM_WIDTH-1:0] b);
        logic signed [SUM_WIDTH:0] s;
        begin
            s = (SUM_WIDTH+1)'(a) + (SUM_WIDTH+1)'(b);
            if (s[SUM_WIDTH] != s[SUM_WIDTH-1])
            begin
                sat_add = s[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                       : {1'b0, {(SUM_WIDTH-1){1'b1}}};
            end
            else
            begin
                sat_add = s[SUM_WIDTH-1:0];
            end
        end
    endfunction

    function automatic logic signed [SUM_WIDTH-1:0] clamp_cross(
        input logic signed [CROSS_WIDTH-1:0] v);
        logic signed [127:0] w;
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        begin
            w  = 128'(v);
            hi = (128'sd1 <<< (SUM_WIDTH - 1)) - 128'sd1;
            lo = -hi - 128'sd1;
            if (w > hi)
                clamp_cross = hi[SUM_WIDTH-1:0];
            else if (w < lo)
                clamp_cross = lo[SUM_WIDTH-1:0];
            else
                clamp_cross = w[SUM_WIDTH-1:0];
        end
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] to_out(
        input logic signed [SUM_WIDTH-1:0] v);
        logic signed [127:0] w;
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        begin
            w  = 128'(v);
            hi = (128'sd1 <<< (OUT_WIDTH - 1)) - 128'sd1;
            lo = -hi - 128'sd1;
            if (w > hi)
                to_out = hi[OUT_WIDTH-1:0];
            else if (w < lo)
                to_out = lo[OUT_WIDTH-1:0];
            else
                to_out = w[OUT_WIDTH-1:0];
        end
    endfunction

endpackage

>>> rtl/vertex_normal_accumulator_unit.sv
// Channel   Handshake          Word
// in        valid / stall      in_word_t: op, slot, coordinates, three corners
// out       valid / stall      out_word_t: kind, three normal components
//
// A load is executed as the back end takes it; a read reads the sum store and
// then emits its word; a face does three vertex reads, a multiply and a subtract
// stage, then three accumulator read-modify-writes. A queued word is registered
// in the front queue before the back end can take it.
// After reset all 1024 entries of the sum store are swept to zero; no word is
// executed meanwhile, though two words may queue.
// A stalled output holds the executing word; the front queue accepts until
// both of its entries are full.
module vertex_normal_accumulator_unit
    import vna_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    vna_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    vna_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .valid     (out_valid),
        .stall     (out_stall),
        .data      (out_data)
    );

endmodule

>>> rtl/vna_front.sv
module vna_front
    import vna_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_word_t in_data,
    output logic     cmd_valid,
    input  logic     cmd_pop,
    output cmd_t     cmd
);

    localparam int QD = 2;

    cmd_t       q_reg [QD];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       enc;
    logic       push;

    always_comb
    begin
        enc.op       = in_data.op;
        enc.in_range = {in_depth(in_data.corner_c), in_depth(in_data.corner_b),
                        in_depth(in_data.corner_a)};
        enc.idx_a    = idx_cut(in_data.corner_a);
        enc.idx_b    = idx_cut(in_data.corner_b);
        enc.idx_c    = idx_cut(in_data.corner_c);
        enc.cx       = coord_cut(in_data.coord_x);
        enc.cy       = coord_cut(in_data.coord_y);
        enc.cz       = coord_cut(in_data.coord_z);
        // Load and read carry their slot in the first corner position.
        if (in_data.op != OP_FACE)
        begin
            enc.idx_a       = idx_cut(in_data.vert_index);
            enc.in_range[0] = in_depth(in_data.vert_index);
        end
    end

    assign in_stall  = (cnt_reg == 2'(QD));
    // A no-operation word is consumed here and never queued.
    assign push      = in_valid && !in_stall && (in_data.op != OP_NOP);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ cmd_pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= enc;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QD)) else $error("queue count overflow");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid) else $error("pop from empty queue");
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'(QD)) |-> in_stall) else $error("full queue not stalling");

endmodule

>>> rtl/vna_back.sv
module vna_back
    import vna_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_pop,
    input  cmd_t      cmd,
    output logic      valid,
    input  logic      stall,
    output out_word_t data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDV0  = 4'd1;
    localparam logic [3:0] S_RDV1  = 4'd2;
    localparam logic [3:0] S_RDV2  = 4'd3;
    localparam logic [3:0] S_MUL   = 4'd4;
    localparam logic [3:0] S_SUB   = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_ACCW  = 4'd7;
    localparam logic [3:0] S_READ  = 4'd8;
    localparam logic [3:0] S_RDOUT = 4'd9;
    localparam logic [3:0] S_CLR   = 4'd10;

    localparam int VW = 3 * COORD_WIDTH;
    localparam int NW = 3 * SUM_WIDTH;

    logic [VW-1:0] vmem [VERTEX_DEPTH];
    logic [NW-1:0] nmem [VERTEX_DEPTH];

    logic [3:0]           state_reg, state_next;
    cmd_t                 cur_reg;
    logic [1:0]           step_reg;
    logic [VW-1:0]        vrd_reg;
    logic [NW-1:0]        nrd_reg;
    logic signed [COORD_WIDTH-1:0] pa_reg [3];
    logic signed [EDGE_WIDTH-1:0]  s_reg [3];
    logic signed [PROD_WIDTH-1:0]  m_reg [6];
    logic signed [SUM_WIDTH-1:0]   n_reg [3];
    logic                 out_valid_reg;
    out_word_t            out_reg;
    logic                 clr_busy_reg;
    logic [IDX_WIDTH:0]   clr_cnt_reg;

    logic [IDX_WIDTH-1:0] corner;
    logic                 corner_ok;
    logic signed [COORD_WIDTH-1:0] vc [3];
    logic signed [SUM_WIDTH-1:0]   oldn [3];
    logic                 out_free;

    assign out_free = !out_valid_reg || !stall;
    assign valid    = out_valid_reg;
    assign data     = out_reg;
    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid && !clr_busy_reg;

    always_comb
    begin
        unique case (step_reg)
            2'd0:    begin corner = cur_reg.idx_a; corner_ok = cur_reg.in_range[0]; end
            2'd1:    begin corner = cur_reg.idx_b; corner_ok = cur_reg.in_range[1]; end
            default: begin corner = cur_reg.idx_c; corner_ok = cur_reg.in_range[2]; end
        endcase
        vc[0]   = vrd_reg[VW-1 -: COORD_WIDTH];
        vc[1]   = vrd_reg[2*COORD_WIDTH-1 -: COORD_WIDTH];
        vc[2]   = vrd_reg[COORD_WIDTH-1:0];
        for (int k = 0; k < 3; k++)
            oldn[k] = nrd_reg[NW-1-k*SUM_WIDTH -: SUM_WIDTH];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (cmd_pop)
                begin
                    unique case (cmd.op)
                        OP_LOAD: state_next = S_IDLE;
                        OP_FACE: state_next = S_RDV0;
                        default: state_next = S_READ;
                    endcase
                end
            S_RDV0:  state_next = S_RDV1;
            S_RDV1:  state_next = S_RDV2;
            S_RDV2:  state_next = S_MUL;
            S_MUL:   state_next = S_SUB;
            S_SUB:   state_next = out_free ? S_ACC : S_SUB;
            S_ACC:   state_next = S_ACCW;
            S_ACCW:  state_next = (step_reg == 2'd2) ? S_IDLE : S_ACC;
            S_READ:  state_next = S_RDOUT;
            S_RDOUT: state_next = out_free ? S_IDLE : S_RDOUT;
            S_CLR:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + (IDX_WIDTH+1)'(1);
                if (clr_cnt_reg == (IDX_WIDTH+1)'(VERTEX_DEPTH - 1))
                    clr_busy_reg <= 1'b0;
            end
            if ((state_reg == S_SUB || state_reg == S_RDOUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !stall)
                out_valid_reg <= 1'b0;
            if (state_reg == S_IDLE || state_reg == S_SUB)
                step_reg <= 2'd0;
            else if (state_reg == S_RDV0 || state_reg == S_RDV1 || state_reg == S_ACCW)
                step_reg <= step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        // The sum store is swept to zero after reset, one entry per cycle.
        if (clr_busy_reg)
            nmem[clr_cnt_reg[IDX_WIDTH-1:0]] <= '0;
        if (cmd_pop)
            cur_reg <= cmd;
        if (cmd_pop && cmd.op == OP_LOAD && cmd.in_range[0])
        begin
            vmem[cmd.idx_a] <= {cmd.cx, cmd.cy, cmd.cz};
            nmem[cmd.idx_a] <= '0;
        end
        if (state_reg == S_RDV0 || state_reg == S_RDV1 || state_reg == S_RDV2)
            vrd_reg <= corner_ok ? vmem[corner] : '0;
        if (state_reg == S_RDV1)
            for (int k = 0; k < 3; k++)
                pa_reg[k] <= vc[k];
        if (state_reg == S_RDV2)
            for (int k = 0; k < 3; k++)
                s_reg[k] <= EDGE_WIDTH'(vc[k]) - EDGE_WIDTH'(pa_reg[k]);
        if (state_reg == S_SUB)
        begin
            for (int k = 0; k < 3; k++)
                n_reg[k] <= clamp_cross(CROSS_WIDTH'(m_reg[2*k]) - CROSS_WIDTH'(m_reg[2*k+1]));
        end
        if (state_reg == S_ACC || state_reg == S_READ)
            nrd_reg <= nmem[corner];
        if (state_reg == S_ACCW && corner_ok)
            nmem[corner] <= {sat_add(oldn[0], n_reg[0]), sat_add(oldn[1], n_reg[1]),
                             sat_add(oldn[2], n_reg[2])};
        if (state_reg == S_SUB && out_free)
        begin
            out_reg.kind   <= KIND_FACE;
            out_reg.norm_x <= to_out(clamp_cross(CROSS_WIDTH'(m_reg[0]) - CROSS_WIDTH'(m_reg[1])));
            out_reg.norm_y <= to_out(clamp_cross(CROSS_WIDTH'(m_reg[2]) - CROSS_WIDTH'(m_reg[3])));
            out_reg.norm_z <= to_out(clamp_cross(CROSS_WIDTH'(m_reg[4]) - CROSS_WIDTH'(m_reg[5])));
        end
        if (state_reg == S_RDOUT && out_free)
        begin
            out_reg.kind   <= KIND_VERT;
            out_reg.norm_x <= cur_reg.in_range[0] ? to_out(oldn[0]) : '0;
            out_reg.norm_y <= cur_reg.in_range[0] ? to_out(oldn[1]) : '0;
            out_reg.norm_z <= cur_reg.in_range[0] ? to_out(oldn[2]) : '0;
        end
    end

    // Six products, taken with the third corner arriving as t.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            m_reg[0] <= s_reg[1] * (EDGE_WIDTH'(vc[2]) - EDGE_WIDTH'(pa_reg[2]));
            m_reg[1] <= (EDGE_WIDTH'(vc[1]) - EDGE_WIDTH'(pa_reg[1])) * s_reg[2];
            m_reg[2] <= s_reg[2] * (EDGE_WIDTH'(vc[0]) - EDGE_WIDTH'(pa_reg[0]));
            m_reg[3] <= (EDGE_WIDTH'(vc[2]) - EDGE_WIDTH'(pa_reg[2])) * s_reg[0];
            m_reg[4] <= s_reg[0] * (EDGE_WIDTH'(vc[1]) - EDGE_WIDTH'(pa_reg[1]));
            m_reg[5] <= (EDGE_WIDTH'(vc[0]) - EDGE_WIDTH'(pa_reg[0])) * s_reg[1];
        end
    end

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == S_IDLE)) else $error("pop while busy");
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !cmd_pop) else $error("pop during clear");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && stall) |=> valid) else $error("word dropped");

endmodule

>>> tb/vertex_normal_checker.sv
module vertex_normal_checker
    import vna_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_word_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_word_t out_data,
    output int        fail_count,
    output int        pending_count
);

    logic signed [63:0] vert_pos [VERTEX_DEPTH][3];
    logic signed [63:0] norm_sum [VERTEX_DEPTH][3];
    out_word_t          expected_words [$];

    function automatic logic signed [63:0] clamp_w(input logic signed [63:0] v, input int w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        begin
            hi = (64'sd1 <<< (w - 1)) - 64'sd1;
            lo = -hi - 64'sd1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        end
    endfunction

    function automatic logic [OUT_WIDTH-1:0] out_bits(input logic signed [63:0] v);
        logic signed [63:0] c;
        begin
            c = clamp_w(v, OUT_WIDTH);
            return c[OUT_WIDTH-1:0];
        end
    endfunction

    task automatic predict_normals(input in_word_t w);
        out_word_t          r;
        logic [9:0]         cn [3];
        logic signed [63:0] p [3][3];
        logic signed [63:0] s [3];
        logic signed [63:0] t [3];
        logic signed [63:0] n [3];
        logic signed [63:0] cv;
        begin
            if (w.op == OP_LOAD)
            begin
                if (w.vert_index < VERTEX_DEPTH)
                begin
                    cv = 64'(w.coord_x); vert_pos[w.vert_index][0] = cv;
                    cv = 64'(w.coord_y); vert_pos[w.vert_index][1] = cv;
                    cv = 64'(w.coord_z); vert_pos[w.vert_index][2] = cv;
                    for (int k = 0; k < 3; k++) norm_sum[w.vert_index][k] = 0;
                end
            end
            else if (w.op == OP_READ)
            begin
                r.kind = KIND_VERT;
                r.norm_x = (w.vert_index < VERTEX_DEPTH) ? out_bits(norm_sum[w.vert_index][0]) : '0;
                r.norm_y = (w.vert_index < VERTEX_DEPTH) ? out_bits(norm_sum[w.vert_index][1]) : '0;
                r.norm_z = (w.vert_index < VERTEX_DEPTH) ? out_bits(norm_sum[w.vert_index][2]) : '0;
                expected_words = {expected_words, r};
            end
            else if (w.op == OP_FACE)
            begin
                cn[0] = w.corner_a; cn[1] = w.corner_b; cn[2] = w.corner_c;
                for (int j = 0; j < 3; j++)
                    for (int k = 0; k < 3; k++)
                        p[j][k] = (cn[j] < VERTEX_DEPTH) ? vert_pos[cn[j]][k] : 0;
                for (int k = 0; k < 3; k++)
                begin
                    s[k] = p[1][k] - p[0][k];
                    t[k] = p[2][k] - p[0][k];
                end
                n[0] = clamp_w(s[1] * t[2] - t[1] * s[2], SUM_WIDTH);
                n[1] = clamp_w(s[2] * t[0] - t[2] * s[0], SUM_WIDTH);
                n[2] = clamp_w(s[0] * t[1] - t[0] * s[1], SUM_WIDTH);
                for (int j = 0; j < 3; j++)
                    if (cn[j] < VERTEX_DEPTH)
                        for (int k = 0; k < 3; k++)
                            norm_sum[cn[j]][k] = clamp_w(norm_sum[cn[j]][k] + n[k], SUM_WIDTH);
                r.kind = KIND_FACE;
                r.norm_x = out_bits(n[0]);
                r.norm_y = out_bits(n[1]);
                r.norm_z = out_bits(n[2]);
                expected_words = {expected_words, r};
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < VERTEX_DEPTH; i++)
            for (int k = 0; k < 3; k++)
            begin
                vert_pos[i][k] = 0;
                norm_sum[i][k] = 0;
            end
    end

    assign pending_count = expected_words.size();

    always @(posedge clk)
    begin
        out_word_t e;
        int        errs;
        errs = 0;
        if (!rst_n)
            fail_count <= 0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected output word: kind %0d", out_data.kind);
                    errs = errs + 1;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (e.kind !== out_data.kind)
                    begin
                        $error("kind: expected %0d actual %0d", e.kind, out_data.kind);
                        errs = errs + 1;
                    end
                    if (e.norm_x !== out_data.norm_x)
                    begin
                        $error("norm_x: expected %0d actual %0d", e.norm_x, out_data.norm_x);
                        errs = errs + 1;
                    end
                    if (e.norm_y !== out_data.norm_y)
                    begin
                        $error("norm_y: expected %0d actual %0d", e.norm_y, out_data.norm_y);
                        errs = errs + 1;
                    end
                    if (e.norm_z !== out_data.norm_z)
                    begin
                        $error("norm_z: expected %0d actual %0d", e.norm_z, out_data.norm_z);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
            // Predict after popping so a same-cycle accept never matches itself.
            if (in_valid && !in_stall)
                predict_normals(in_data);
        end
    end

endmodule

>>> tb/vertex_normal_accumulator_unit_tb.sv
module vertex_normal_accumulator_unit_tb
    import vna_pkg::*;
;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_data;
    int        fail_count;
    int        pending_count;
    int        cycle_count;
    bit        quiet_phase;
    bit        loaded [VERTEX_DEPTH];
    int        loaded_list [$];

    localparam int CYCLE_LIMIT = 400000;

    vertex_normal_accumulator_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    vertex_normal_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver stalls in random bursts until the quiet phase.
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet_phase && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 8);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input in_word_t w);
        int n;
        begin
            if (!quiet_phase && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 8);
                in_valid <= 1'b0;
                repeat (n) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= w;
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end
    endtask

    function automatic in_word_t noise_word();
        in_word_t    w;
        logic [95:0] r;
        begin
            r = {$urandom, $urandom, $urandom};
            w = r[$bits(in_word_t)-1:0];
            return w;
        end
    endfunction

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_vertex(input int idx, input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        in_word_t w;
        begin
            w = noise_word();
            w.op = OP_LOAD; w.vert_index = idx[9:0];
            w.coord_x = x; w.coord_y = y; w.coord_z = z;
            send_word(w);
            if (!loaded[idx]) loaded_list = {loaded_list, idx};
            loaded[idx] = 1'b1;
        end
    endtask

    task automatic face_word(input int a, input int b, input int c);
        in_word_t w;
        begin
            w = noise_word();
            w.op = OP_FACE;
            w.corner_a = a[9:0]; w.corner_b = b[9:0]; w.corner_c = c[9:0];
            send_word(w);
        end
    endtask

    task automatic read_word(input int idx);
        in_word_t w;
        begin
            w = noise_word();
            w.op = OP_READ; w.vert_index = idx[9:0];
            send_word(w);
        end
    endtask

    function automatic int any_loaded();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    initial
    begin
        in_word_t w;
        int k;
        quiet_phase = 1'b0;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        for (int i = 0; i < VERTEX_DEPTH; i++) loaded[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b0;
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed: extreme coordinates give full-scale edge vectors for the cross product.
        load_vertex(0, 16'h8000, 16'h8000, 16'h8000);
        load_vertex(1, 16'h7fff, 16'h8000, 16'h7fff);
        load_vertex(2, 16'h8000, 16'h7fff, 16'h7fff);
        load_vertex(1023, 16'h7fff, 16'h7fff, 16'h8000);
        load_vertex(5, 16'h0100, 16'h0000, 16'h0000);
        read_word(0);
        face_word(0, 1, 2);
        face_word(0, 1, 2);
        face_word(1023, 0, 1);
        face_word(0, 0, 0);
        face_word(5, 5, 1);
        read_word(0);
        read_word(1);
        read_word(2);
        read_word(1023);
        read_word(5);
        load_vertex(0, 16'h0000, 16'h0000, 16'h0000);
        read_word(0);
        w = noise_word(); w.op = OP_NOP; send_word(w);
        read_word(700);
        // Drive four faces on vertices 1, 2 and 1023 so their sums accumulate.
        repeat (4) face_word(1, 2, 1023);
        read_word(1);

        for (int i = 0; i < 1700; i++)
        begin
            if (i > 1500) quiet_phase = 1'b1;
            k = $urandom_range(0, 99);
            if (k < 25 || loaded_list.size() < 3)
            begin
                // Small slot range most of the time so faces revisit vertices.
                load_vertex(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, 15),
                            pick_coord(), pick_coord(), pick_coord());
            end
            else if (k < 70)
                face_word(any_loaded(), any_loaded(), any_loaded());
            else if (k < 92)
                read_word(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : any_loaded());
            else
            begin
                w = noise_word();
                w.op = OP_NOP;
                send_word(w);
            end
        end
        in_valid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/vna_pkg.sv
rtl/vna_front.sv
rtl/vna_back.sv
rtl/vertex_normal_accumulator_unit.sv
tb/vertex_normal_checker.sv
tb/vertex_normal_accumulator_unit_tb.sv
